### rtl/ddc_pkg.sv
package ddc_pkg;

    // Message counter width
    localparam int CountBits = 16;
    localparam int TickBits  = 16;
    localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

    // Wheel speed arithmetic
    localparam int BaseBits  = 18;                    // L * 1000 < 2^18
    localparam int TurnBits  = 23;                    // A (7 bits) * gain (16 bits)
    localparam int SpeedBits = 25;                    // signed wheel speed
    localparam int MagBits   = SpeedBits - 1;         // |v| < 2^24
    localparam int ScaleBits = 18;                    // (|v| * 255) >> 8, when in range
    localparam logic [9:0]  MilliScale = 10'd1000;
    localparam logic [23:0] ScaleLimit = 24'd256000;  // quotient would reach 256
    // floor(z / 1000) = (z * RecipMul) >> RecipShift for z < 256000
    localparam logic [18:0] RecipMul   = 19'd268436;
    localparam int          RecipShift = 28;
    localparam int          ProdBits   = ScaleBits + 19;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_PWM_LIMIT     = 2'd0,
        REG_TURN_GAIN     = 2'd1,
        REG_WINDOW_TICKS  = 2'd2,
        REG_SNAPSHOT_TICK = 2'd3
    } reg_idx_t;

    // Configuration reset values
    localparam logic [7:0]  PwmLimitReset     = 8'd253;
    localparam logic [15:0] TurnGainReset     = 16'd4396;
    localparam logic [15:0] WindowTicksReset  = 16'd250;
    localparam logic [15:0] SnapshotTickReset = 16'd50;

    // Input item selector
    localparam logic FuncCommand = 1'b0;

    typedef struct packed {
        logic        func;
        logic [31:0] command;
    } cmd_t;

    typedef struct packed {
        logic [7:0] pwm_track_a;
        logic [7:0] pwm_wheel_l;
        logic [7:0] pwm_wheel_r;
        logic       dir_track_a;
        logic       dir_left;
        logic       dir_right;
        logic       relay_one;
        logic       relay_two;
        logic       relay_three_four;
        logic       sweep_one_enable;
        logic       sweep_two_enable;
        logic       host_online;
    } res_t;

    typedef struct packed {
        logic [7:0]  pwm_limit;
        logic [15:0] turn_gain;
        logic [15:0] window_ticks;
        logic [15:0] snapshot_tick;
    } cfg_t;

    // Latest command and online flag after the state update
    typedef struct packed {
        logic [31:0] command;
        logic        online;
    } s1_t;

    // Flag byte is command bits 31:24
    typedef struct packed {
        logic [BaseBits-1:0] base;
        logic [TurnBits-1:0] turn;
        logic                sense;
        logic [7:0]          track_duty;
        logic [7:0]          flags;
        logic                online;
    } s2_t;

    typedef struct packed {
        logic signed [SpeedBits-1:0] vl;
        logic signed [SpeedBits-1:0] vr;
        logic [7:0]                  track_duty;
        logic [7:0]                  flags;
        logic                        online;
    } s3_t;

    typedef struct packed {
        logic [ScaleBits-1:0] zl;
        logic [ScaleBits-1:0] zr;
        logic                 big_l;
        logic                 big_r;
        logic                 dir_l;
        logic                 dir_r;
        logic [7:0]           track_duty;
        logic [7:0]           flags;
        logic                 online;
    } s4_t;

endpackage

### rtl/ddc_state.sv
module ddc_state (
    input  logic                clk,
    input  logic                rst_n,
    input  ddc_pkg::cfg_t       cfg,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  ddc_pkg::cmd_t       cmd,
    output logic                s1_valid,
    input  logic                s1_ready,
    output ddc_pkg::s1_t        s1
);
    import ddc_pkg::*;

    logic [31:0]          last_reg,   last_next;
    logic [TickBits-1:0]  tick_reg,   tick_next;
    logic [CountBits-1:0] msg_reg,    msg_next;
    logic [CountBits-1:0] snap_reg,   snap_next;
    logic                 online_reg, online_next;
    logic                 s1_valid_reg;
    s1_t                  s1_reg;
    logic                 accept;
    logic [TickBits-1:0]  tick_inc;

    assign cmd_ready = !s1_valid_reg || s1_ready;
    assign accept    = cmd_valid && cmd_ready;
    assign tick_inc  = tick_reg + TickBits'(1);

    // Update host state for one word
    always_comb
    begin
        last_next   = last_reg;
        tick_next   = tick_reg;
        msg_next    = msg_reg;
        snap_next   = snap_reg;
        online_next = online_reg;
        if (accept)
        begin
            if (cmd.func == FuncCommand)
            begin
                last_next = cmd.command;
                if (msg_reg != CountMax)
                begin
                    msg_next = msg_reg + CountBits'(1);
                end
            end
            else
            begin
                tick_next = tick_inc;
                if (tick_inc == cfg.snapshot_tick)
                begin
                    snap_next = msg_reg;
                end
                if (tick_inc >= cfg.window_ticks)
                begin
                    online_next = (msg_reg > snap_next);
                    tick_next   = '0;
                    msg_next    = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg     <= '0;
            tick_reg     <= '0;
            msg_reg      <= '0;
            snap_reg     <= '0;
            online_reg   <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            last_reg   <= last_next;
            tick_reg   <= tick_next;
            msg_reg    <= msg_next;
            snap_reg   <= snap_next;
            online_reg <= online_next;
            if (cmd_ready)
            begin
                s1_valid_reg <= cmd_valid;
            end
        end
    end

    // Capture the updated command and flag
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg.command <= last_next;
            s1_reg.online  <= online_next;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1       = s1_reg;

endmodule

### rtl/ddc_kin.sv
module ddc_kin (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [15:0]         turn_gain,
    input  logic                s1_valid,
    output logic                s1_ready,
    input  ddc_pkg::s1_t        s1,
    output logic                s4_valid,
    input  logic                s4_ready,
    output ddc_pkg::s4_t        s4
);
    import ddc_pkg::*;

    s2_t  s2_reg, s2_next;
    s3_t  s3_reg, s3_next;
    s4_t  s4_reg, s4_next;
    logic s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s3_ready, s4_take;

    logic [15:0]          track_scaled;
    logic [MagBits-1:0]   mag_l, mag_r;
    logic [31:0]          prod_l, prod_r;
    logic [MagBits-1:0]   quot_l, quot_r;

    // Ready chain through the three stages
    assign s4_take  = !s4_valid_reg || s4_ready;
    assign s3_ready = !s3_valid_reg || s4_take;
    assign s1_ready = !s2_valid_reg || s3_ready;

    // Stage two: turn product, base speed, track duty
    always_comb
    begin
        track_scaled       = {s1.command[23:16], 8'h00} - {8'h00, s1.command[23:16]};
        s2_next.base       = BaseBits'(s1.command[15:8]) * BaseBits'(MilliScale);
        s2_next.turn       = TurnBits'(s1.command[6:0]) * TurnBits'(turn_gain);
        s2_next.sense      = s1.command[7];
        s2_next.track_duty = track_scaled[15:8];
        s2_next.flags      = s1.command[31:24];
        s2_next.online     = s1.online;
    end

    // Stage three: wheel speeds, thousandths of a linear step
    always_comb
    begin
        if (s2_reg.sense)
        begin
            s3_next.vl = $signed(SpeedBits'(s2_reg.base)) - $signed(SpeedBits'(s2_reg.turn));
            s3_next.vr = $signed(SpeedBits'(s2_reg.base)) + $signed(SpeedBits'(s2_reg.turn));
        end
        else
        begin
            s3_next.vl = $signed(SpeedBits'(s2_reg.base)) + $signed(SpeedBits'(s2_reg.turn));
            s3_next.vr = $signed(SpeedBits'(s2_reg.base)) - $signed(SpeedBits'(s2_reg.turn));
        end
        s3_next.track_duty = s2_reg.track_duty;
        s3_next.flags      = s2_reg.flags;
        s3_next.online     = s2_reg.online;
    end

    // Stage four: magnitude times 255 over 256, range check, direction
    always_comb
    begin
        mag_l  = s3_reg.vl[SpeedBits-1] ? MagBits'(-s3_reg.vl) : MagBits'(s3_reg.vl);
        mag_r  = s3_reg.vr[SpeedBits-1] ? MagBits'(-s3_reg.vr) : MagBits'(s3_reg.vr);
        prod_l = {mag_l, 8'h00} - {8'h00, mag_l};
        prod_r = {mag_r, 8'h00} - {8'h00, mag_r};
        quot_l = prod_l[31:8];
        quot_r = prod_r[31:8];
        s4_next.zl         = quot_l[ScaleBits-1:0];
        s4_next.zr         = quot_r[ScaleBits-1:0];
        s4_next.big_l      = (quot_l >= ScaleLimit);
        s4_next.big_r      = (quot_r >= ScaleLimit);
        s4_next.dir_l      = s3_reg.flags[2] ~^ !s3_reg.vl[SpeedBits-1];
        s4_next.dir_r      = s3_reg.flags[2] ~^ !s3_reg.vr[SpeedBits-1];
        s4_next.track_duty = s3_reg.track_duty;
        s4_next.flags      = s3_reg.flags;
        s4_next.online     = s3_reg.online;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s2_valid_reg <= s1_valid;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_take)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    // Advance payloads where the next stage is free
    always_ff @(posedge clk)
    begin
        if (s1_valid && s1_ready)
        begin
            s2_reg <= s2_next;
        end
        if (s2_valid_reg && s3_ready)
        begin
            s3_reg <= s3_next;
        end
        if (s3_valid_reg && s4_take)
        begin
            s4_reg <= s4_next;
        end
    end

    assign s4_valid = s4_valid_reg;
    assign s4       = s4_reg;

endmodule

### rtl/ddc_out.sv
module ddc_out (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          pwm_limit,
    input  logic                s4_valid,
    output logic                s4_ready,
    input  ddc_pkg::s4_t        s4,
    output logic                res_valid,
    input  logic                res_ready,
    output ddc_pkg::res_t       res
);
    import ddc_pkg::*;

    res_t                res_reg, res_next;
    logic                res_valid_reg;
    logic [ProdBits-1:0] prod_l, prod_r;
    logic [7:0]          duty_l, duty_r;
    logic                gate;

    assign s4_ready = !res_valid_reg || res_ready;
    assign gate     = s4.online;

    // Divide by 1000 through the reciprocal, then clamp and gate
    always_comb
    begin
        prod_l = ProdBits'(s4.zl) * ProdBits'(RecipMul);
        prod_r = ProdBits'(s4.zr) * ProdBits'(RecipMul);
        duty_l = prod_l[RecipShift+7:RecipShift];
        duty_r = prod_r[RecipShift+7:RecipShift];

        res_next.pwm_track_a = '0;
        res_next.pwm_wheel_l = '0;
        res_next.pwm_wheel_r = '0;
        if (gate)
        begin
            res_next.pwm_track_a = (s4.track_duty > pwm_limit) ? pwm_limit : s4.track_duty;
            res_next.pwm_wheel_l = (s4.big_l || duty_l > pwm_limit) ? pwm_limit : duty_l;
            res_next.pwm_wheel_r = (s4.big_r || duty_r > pwm_limit) ? pwm_limit : duty_r;
        end
        res_next.dir_track_a      = s4.flags[1];
        res_next.dir_left         = s4.dir_l;
        res_next.dir_right        = s4.dir_r;
        res_next.relay_one        = gate & s4.flags[4];
        res_next.relay_two        = gate & s4.flags[5];
        res_next.relay_three_four = gate & (s4.flags[6] | s4.flags[7]);
        res_next.sweep_one_enable = gate & s4.flags[0];
        res_next.sweep_two_enable = gate & s4.flags[3];
        res_next.host_online      = gate;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (s4_ready)
        begin
            res_valid_reg <= s4_valid;
        end
    end

    // Hold the result word until taken
    always_ff @(posedge clk)
    begin
        if (s4_valid && s4_ready)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

### rtl/diff_drive_command_decoder.sv
// Drive command decoder for a tracked and a wheeled base. Each word on cmd is
// either a 32-bit drive command (func 0) or one 2 ms tick (func 1), and each
// gives exactly one result word on res, built from the latest command and the
// host-online flag. The block takes one word per cycle while cmd_ready is high;
// each word passes through the five-register pipeline (state update, turn
// product, wheel speeds, scaling, reciprocal divide and clamp). A low
// res_ready holds results in place and backs up to cmd_ready once every
// stage is full.
// Ticks run a judgement window of window_ticks; the message count is sampled
// at snapshot_tick, and at the end of the window the host is online if more
// commands arrived since. While offline the PWM, relay and sweep outputs read
// zero; direction levels still follow the command. Write configuration only
// while no word is in flight.
module diff_drive_command_decoder (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wen,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_wdata,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  ddc_pkg::cmd_t       cmd,
    output logic                res_valid,
    input  logic                res_ready,
    output ddc_pkg::res_t       res
);
    import ddc_pkg::*;

    cfg_t cfg_reg;
    logic s1_valid, s1_ready;
    s1_t  s1;
    logic s4_valid, s4_ready;
    s4_t  s4;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pwm_limit     <= PwmLimitReset;
            cfg_reg.turn_gain     <= TurnGainReset;
            cfg_reg.window_ticks  <= WindowTicksReset;
            cfg_reg.snapshot_tick <= SnapshotTickReset;
        end
        else if (cfg_wen)
        begin
            case (reg_idx_t'(cfg_index))
                REG_PWM_LIMIT:     cfg_reg.pwm_limit     <= cfg_wdata[7:0];
                REG_TURN_GAIN:     cfg_reg.turn_gain     <= cfg_wdata;
                REG_WINDOW_TICKS:  cfg_reg.window_ticks  <= cfg_wdata;
                REG_SNAPSHOT_TICK: cfg_reg.snapshot_tick <= cfg_wdata;
                default:           cfg_reg.pwm_limit     <= cfg_reg.pwm_limit;
            endcase
        end
    end

    ddc_state u_state (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .s1_valid  (s1_valid),
        .s1_ready  (s1_ready),
        .s1        (s1)
    );

    ddc_kin u_kin (
        .clk       (clk),
        .rst_n     (rst_n),
        .turn_gain (cfg_reg.turn_gain),
        .s1_valid  (s1_valid),
        .s1_ready  (s1_ready),
        .s1        (s1),
        .s4_valid  (s4_valid),
        .s4_ready  (s4_ready),
        .s4        (s4)
    );

    ddc_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .pwm_limit (cfg_reg.pwm_limit),
        .s4_valid  (s4_valid),
        .s4_ready  (s4_ready),
        .s4        (s4),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Offline results carry no drive
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.host_online |->
            res.pwm_wheel_l == 8'd0 && res.pwm_wheel_r == 8'd0 && res.pwm_track_a == 8'd0
            && !res.relay_one && !res.relay_two && !res.relay_three_four
            && !res.sweep_one_enable && !res.sweep_two_enable)
        else $error("drive output while host offline");

    // Duties never exceed the ceiling
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res.pwm_wheel_l <= cfg_reg.pwm_limit
            && res.pwm_wheel_r <= cfg_reg.pwm_limit
            && res.pwm_track_a <= cfg_reg.pwm_limit)
        else $error("duty above limit");

    // A stalled output still lets the pipeline take a word while it has room
    assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid && !s4_valid |-> cmd_ready)
        else $error("input blocked with empty pipeline");

endmodule
